// ----- src/pbms_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pbms_pkg
// Shared constants, types and command/status structs of the plane search.
// ============================================================================
package pbms_pkg;

    function automatic int max_int(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

    localparam int MAX_PLANES  = 16;
    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = 12;

    localparam int IDX_W       = $clog2(MAX_PLANES);
    localparam int CNT_W       = $clog2(MAX_PLANES + 1);
    localparam int PLANE_W     = 4 * COEF_BITS;

    localparam int WEIGHT_W    = 12;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 12'd410;

    localparam int QNUM_W      = 8;
    localparam int BEST_IDX_W  = 4;
    localparam int SCORE_W     = 21;

    localparam int PROD_W      = 2 * COEF_BITS;
    localparam int DOT_W       = PROD_W + 2;
    localparam int DIFF_W      = COEF_BITS + 1;
    localparam int PEN_W       = DIFF_W + WEIGHT_W;
    // room for the floor of -99 at 24 fraction bits
    localparam int SC_W        = max_int(max_int(DOT_W, PEN_W) + 1, 33);
    localparam int SH_W        = SC_W - FRAC_BITS;

    localparam logic signed [SC_W-1:0] SCORE_FLOOR =
        SC_W'(-64'sd99 * (64'sd1 <<< (2 * FRAC_BITS)));
    localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'((64'sd1 <<< (SCORE_W - 1)) - 64'sd1);
    localparam logic signed [SH_W-1:0] SAT_MIN = SH_W'(-(64'sd1 <<< (SCORE_W - 1)));

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_QUERY  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] normal_x;
        logic signed [COEF_BITS-1:0] normal_y;
        logic signed [COEF_BITS-1:0] normal_z;
        logic signed [COEF_BITS-1:0] plane_offset;
    } t_plane;

    typedef struct packed {
        logic             clear;
        logic             append;
        logic             query;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             pipe_busy;
        logic             out_free;
    } t_dp_status;

endpackage

// ----- src/pbms_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pbms interfaces
// Request, result and configuration channels of the plane search.
// ============================================================================
interface pbms_in_if import pbms_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [1:0]                  func;
    logic signed [COEF_BITS-1:0] normal_x;
    logic signed [COEF_BITS-1:0] normal_y;
    logic signed [COEF_BITS-1:0] normal_z;
    logic signed [COEF_BITS-1:0] plane_offset;

    modport source (output valid, func, normal_x, normal_y, normal_z, plane_offset,
                    input ready);
    modport sink   (input valid, func, normal_x, normal_y, normal_z, plane_offset,
                    output ready);
endinterface

interface pbms_out_if import pbms_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [QNUM_W-1:0]         query_number;
    logic                      found;
    logic [BEST_IDX_W-1:0]     best_index;
    logic signed [SCORE_W-1:0] peak_score;

    modport source (output valid, query_number, found, best_index, peak_score,
                    input ready);
    modport sink   (input valid, query_number, found, best_index, peak_score,
                    output ready);
endinterface

interface pbms_cfg_if import pbms_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- src/plane_best_match_search_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// plane_best_match_search_top
// Best-match search of a query plane over a table of reference planes.
// ============================================================================
//  channel   dir   payload                                           handshake
//  i_in      in    func, normal_x, normal_y, normal_z, plane_offset   valid/ready
//  o_out     out   query_number, found, best_index, peak_score        valid/ready
//  i_cfg     in    data (offset_weight)                               valid/ready
//
//  Clear and append complete as they are accepted. During a query the table
//  RAM is read one plane per cycle into a four-stage scoring pipe.
//  The result sits in an output register, so new requests are taken while it
//  waits; a query finishing into a full output register holds until it drains.
//  Synchronous active-low reset empties the table and zeroes the query count.
// ============================================================================
module plane_best_match_search_top import pbms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pbms_in_if.sink    i_in,
    pbms_out_if.source o_out,
    pbms_cfg_if.sink   i_cfg
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_plane     w_plane;

    assign w_plane.normal_x     = i_in.normal_x;
    assign w_plane.normal_y     = i_in.normal_y;
    assign w_plane.normal_z     = i_in.normal_z;
    assign w_plane.plane_offset = i_in.plane_offset;

    pbms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    pbms_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_plane  (w_plane),
        .i_cfg    (i_cfg),
        .o_out    (o_out),
        .o_status (w_status)
    );

endmodule

// ----- src/pbms_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pbms_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module pbms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/pbms_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pbms_ctrl
// Request decode and scan sequencer for the plane search.
// ============================================================================
module pbms_ctrl import pbms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pbms_in_if.sink    i_in,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        o_cmd          = '0;
        o_cmd.rd_addr  = r_idx[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_func'(i_in.func))
                        FUNC_CLEAR:  o_cmd.clear  = 1'b1;
                        FUNC_APPEND: o_cmd.append = 1'b1;
                        FUNC_QUERY: begin
                            o_cmd.query = 1'b1;
                            n_idx       = '0;
                            n_state     = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx < i_status.count) begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = r_idx + CNT_W'(1);
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- src/pbms_dp.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pbms_dp
// Plane table, scoring pipeline, best tracker and result register.
// ============================================================================
module pbms_dp import pbms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_plane     i_plane,
    pbms_cfg_if.sink   i_cfg,
    pbms_out_if.source o_out,
    output t_dp_status o_status
);

    logic [WEIGHT_W-1:0]  r_weight;
    logic [CNT_W-1:0]     r_count;
    logic [QNUM_W-1:0]    r_qcnt;
    logic [QNUM_W-1:0]    r_qnum;
    t_plane               r_query;

    logic                 w_we;
    logic [PLANE_W-1:0]   w_rdata;
    t_plane               w_ref;

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [IDX_W-1:0]     r_idx1, r_idx2, r_idx3, r_idx4;
    logic signed [PROD_W-1:0] r_pa, r_pb, r_pc;
    logic [DIFF_W-1:0]    r_abs;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DOT_W-1:0]  r_dot;
    logic [PEN_W-1:0]     r_pen;
    logic signed [SC_W-1:0]   r_score;

    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic signed [SC_W-1:0]   r_peak_score;

    logic signed [SH_W-1:0]    w_shift;
    logic signed [SCORE_W-1:0] w_sat;
    logic [IDX_W+BEST_IDX_W-1:0] w_idx_ext;

    logic                      r_out_valid;
    logic [QNUM_W-1:0]         r_out_qnum;
    logic                      r_out_found;
    logic [BEST_IDX_W-1:0]     r_out_idx;
    logic signed [SCORE_W-1:0] r_out_score;

    // config register, always ready
    assign i_cfg.ready = 1'b1;

    assign w_we = i_cmd.append && (r_count < CNT_W'(MAX_PLANES));

    pbms_ram #(
        .WIDTH (PLANE_W),
        .DEPTH (MAX_PLANES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_plane),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_rdata)
    );

    assign w_ref  = t_plane'(w_rdata);
    assign w_diff = DIFF_W'(r_query.plane_offset) - DIFF_W'(w_ref.plane_offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight    <= WEIGHT_RESET;
            r_count     <= '0;
            r_qcnt      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_weight <= i_cfg.data;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_qcnt  <= '0;
            end else if (w_we) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.query) begin
                r_qcnt <= r_qcnt + QNUM_W'(1);
            end
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scoring pipeline: read, products, sums, score, compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_query      <= i_plane;
            r_qnum       <= r_qcnt;
            r_found      <= 1'b0;
            r_best_idx   <= '0;
            r_peak_score <= SCORE_FLOOR;
        end else if (r_v4 && (r_score > r_peak_score)) begin
            r_found      <= 1'b1;
            r_best_idx   <= r_idx4;
            r_peak_score <= r_score;
        end
        r_idx1  <= i_cmd.rd_addr;
        r_idx2  <= r_idx1;
        r_idx3  <= r_idx2;
        r_idx4  <= r_idx3;
        r_pa    <= r_query.normal_x * w_ref.normal_x;
        r_pb    <= r_query.normal_y * w_ref.normal_y;
        r_pc    <= r_query.normal_z * w_ref.normal_z;
        r_abs   <= w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
        r_dot   <= DOT_W'(r_pa) + DOT_W'(r_pb) + DOT_W'(r_pc);
        r_pen   <= PEN_W'(r_abs) * PEN_W'(r_weight);
        r_score <= SC_W'(r_dot) - $signed(SC_W'(r_pen));
    end

    // floor to 12 fraction bits, then saturate
    assign w_shift = SH_W'(r_peak_score >>> FRAC_BITS);
    always_comb begin
        if (w_shift > SAT_MAX) begin
            w_sat = SCORE_W'(SAT_MAX);
        end else if (w_shift < SAT_MIN) begin
            w_sat = SCORE_W'(SAT_MIN);
        end else begin
            w_sat = SCORE_W'(w_shift);
        end
    end

    assign w_idx_ext = {BEST_IDX_W'(0), r_best_idx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_qnum  <= r_qnum;
            r_out_found <= r_found;
            r_out_idx   <= r_found ? w_idx_ext[BEST_IDX_W-1:0] : '0;
            r_out_score <= r_found ? w_sat : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.query_number = r_out_qnum;
    assign o_out.found        = r_out_found;
    assign o_out.best_index   = r_out_idx;
    assign o_out.peak_score   = r_out_score;

    assign o_status.count     = r_count;
    assign o_status.pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;
    assign o_status.out_free  = !r_out_valid || o_out.ready;

endmodule
